### rtl/sla_pkg.sv
// Shared constants and defaults for the serial line assembler.
`timescale 1ns / 1ps
package sla_pkg;

   localparam int BYTE_W = 8;
   localparam int CFG_W = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int LINE_MAX_DEFAULT = 64;

   localparam logic [CFG_W-1:0] MAX_OUT_LEN_RESET = 6'd63;
   localparam logic [BYTE_W-1:0] NL_BYTE = 8'd10;
   localparam logic [BYTE_W-1:0] CR_BYTE = 8'd13;
   localparam logic [BYTE_W-1:0] NUL_BYTE = 8'd0;

   // Register index, taken from the word address bit of the CSR port.
   localparam logic REG_MAX_OUT_LEN = 1'b0;

endpackage

### rtl/sla_line_ram.sv
// Line store: single-port-write, single-port-read memory with registered read data.
`timescale 1ns / 1ps
module sla_line_ram #(
   parameter int DEPTH = sla_pkg::LINE_MAX_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [sla_pkg::BYTE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [sla_pkg::BYTE_W-1:0] rd_data
);
   import sla_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/serial_line_assembler.sv
// Serial line assembler: collects bytes into a line store and replays each completed line.
// Order: a byte is stored in the cycle it is accepted; a newline ending a non-empty line starts
// replay: S_READ reads the line store, S_CHECK loads the character into the output register, and
// S_END loads the end marker at the limit or on a zero byte; a held output stalls both.
// Throughput: one ordinary byte per cycle; in replay each character word passes S_READ and
// S_CHECK (the store read is registered); no byte is accepted until the end marker is loaded.
// Reset (synchronous): fill count and control state cleared, max_out_len set to 63.
`timescale 1ns / 1ps
module serial_line_assembler #(
   parameter int LINE_MAX = sla_pkg::LINE_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sla_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sla_pkg::BYTE_W-1:0]      rsp_line_char,
   output logic                            rsp_line_end,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sla_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sla_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sla_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import sla_pkg::*;

   localparam int CNT_W = $clog2(LINE_MAX);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_MAX - 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_END   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              last_cr_ff, last_cr_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  lim_ff, lim_in;
   logic [CFG_W-1:0]  max_out_len_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_end_ff, rsp_end_in;

   logic              req_fire;
   logic              slot_free;
   logic              wr_en;
   logic              rd_en;
   logic [BYTE_W-1:0] rd_data;
   logic              strip_cr;
   logic [CNT_W-1:0]  line_len;
   logic [CFG_W-1:0]  line_len_ext;
   logic [CFG_W-1:0]  lim_ext;
   logic              csr_write;

   sla_line_ram #(
      .DEPTH  (LINE_MAX),
      .ADDR_W (CNT_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_OUT_LEN)
                       ? CSR_DATA_W'(max_out_len_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_out_len_ff <= MAX_OUT_LEN_RESET;
      end else if (csr_write && csr_paddr[2] == REG_MAX_OUT_LEN) begin
         max_out_len_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign wr_en        = req_fire && req_rx_byte != NL_BYTE && fill_ff < CAP;
   assign strip_cr     = last_cr_ff && fill_ff != '0;
   assign line_len     = fill_ff - CNT_W'(strip_cr);
   assign line_len_ext = CFG_W'(line_len);
   assign lim_ext      = (line_len_ext < max_out_len_ff) ? line_len_ext : max_out_len_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      last_cr_in   = last_cr_ff;
      idx_in       = idx_ff;
      lim_in       = lim_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_end_in   = rsp_end_ff;
      rd_en        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_rx_byte != NL_BYTE) begin
                  if (fill_ff < CAP) begin
                     fill_in    = fill_ff + CNT_W'(1);
                     last_cr_in = (req_rx_byte == CR_BYTE);
                  end else begin
                     fill_in    = '0;
                     last_cr_in = 1'b0;
                  end
               end else begin
                  fill_in    = '0;
                  last_cr_in = 1'b0;
                  idx_in     = '0;
                  lim_in     = CNT_W'(lim_ext);
                  if (line_len != '0) begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            if (idx_ff == lim_ff) begin
               state_in = S_END;
            end else begin
               rd_en    = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (rd_data == NUL_BYTE) begin
               state_in = S_END;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = rd_data;
               rsp_end_in   = 1'b0;
               idx_in       = idx_ff + CNT_W'(1);
               state_in     = S_READ;
            end
         end
         S_END: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = NUL_BYTE;
               rsp_end_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         last_cr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         last_cr_ff   <= last_cr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      lim_ff      <= lim_in;
      rsp_char_ff <= rsp_char_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_line_char = rsp_char_ff;
   assign rsp_line_end  = rsp_end_ff;

endmodule

### bench/testbench.sv
// Self-checking testbench for the serial line assembler: directed table, random lines, scoreboard.
`timescale 1ns / 1ps
module testbench;
   import sla_pkg::*;

   localparam int LINE_MAX = LINE_MAX_DEFAULT;
   localparam int LINE_CAP = LINE_MAX - 1;
   localparam int ITEM_TARGET = 480;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 10;
   localparam logic [BYTE_W-1:0] FILL_BASE = 8'h21;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = {REG_MAX_OUT_LEN, 2'b00};

   typedef enum logic [1:0] {ROW_BYTE, ROW_FILL, ROW_LIMIT} row_kind_type;
   typedef enum logic [1:0] {OUTCOME_MODEL, OUTCOME_NONE, OUTCOME_END_ONLY} outcome_type;
   typedef enum logic [1:0] {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_SPARSE} ready_mode_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [BYTE_W-1:0]    value;
      outcome_type          outcome;
   } stim_row_type;

   typedef struct {
      logic [BYTE_W-1:0] ch;
      logic              last;
   } line_word_type;

   localparam int DIRECTED_ROWS = 35;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ROW_BYTE,  NL_BYTE,  OUTCOME_NONE},
      '{ROW_BYTE,  CR_BYTE,  OUTCOME_MODEL},
      '{ROW_BYTE,  NL_BYTE,  OUTCOME_NONE},
      '{ROW_BYTE,  8'h41,    OUTCOME_MODEL},
      '{ROW_BYTE,  8'hFF,    OUTCOME_MODEL},
      '{ROW_BYTE,  8'h01,    OUTCOME_MODEL},
      '{ROW_BYTE,  CR_BYTE,  OUTCOME_MODEL},
      '{ROW_BYTE,  NL_BYTE,  OUTCOME_MODEL},
      '{ROW_BYTE,  NUL_BYTE, OUTCOME_MODEL},
      '{ROW_BYTE,  8'h42,    OUTCOME_MODEL},
      '{ROW_BYTE,  NL_BYTE,  OUTCOME_END_ONLY},
      '{ROW_BYTE,  8'h78,    OUTCOME_MODEL},
      '{ROW_BYTE,  NUL_BYTE, OUTCOME_MODEL},
      '{ROW_BYTE,  NL_BYTE,  OUTCOME_MODEL},
      '{ROW_BYTE,  CR_BYTE,  OUTCOME_MODEL},
      '{ROW_BYTE,  CR_BYTE,  OUTCOME_MODEL},
      '{ROW_BYTE,  NL_BYTE,  OUTCOME_MODEL},
      '{ROW_LIMIT, 8'd0,     OUTCOME_MODEL},
      '{ROW_BYTE,  8'h51,    OUTCOME_MODEL},
      '{ROW_BYTE,  NL_BYTE,  OUTCOME_END_ONLY},
      '{ROW_LIMIT, 8'd2,     OUTCOME_MODEL},
      '{ROW_BYTE,  8'h61,    OUTCOME_MODEL},
      '{ROW_BYTE,  8'h62,    OUTCOME_MODEL},
      '{ROW_BYTE,  8'h63,    OUTCOME_MODEL},
      '{ROW_BYTE,  NL_BYTE,  OUTCOME_MODEL},
      '{ROW_LIMIT, 8'd63,    OUTCOME_MODEL},
      '{ROW_FILL,  8'd63,    OUTCOME_MODEL},
      '{ROW_BYTE,  NL_BYTE,  OUTCOME_MODEL},
      '{ROW_FILL,  8'd63,    OUTCOME_MODEL},
      '{ROW_BYTE,  8'h7A,    OUTCOME_MODEL},
      '{ROW_BYTE,  8'h6B,    OUTCOME_MODEL},
      '{ROW_BYTE,  NL_BYTE,  OUTCOME_MODEL},
      '{ROW_FILL,  8'd62,    OUTCOME_MODEL},
      '{ROW_BYTE,  CR_BYTE,  OUTCOME_MODEL},
      '{ROW_BYTE,  NL_BYTE,  OUTCOME_MODEL}
   };

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [BYTE_W-1:0]       req_rx_byte;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [BYTE_W-1:0]       rsp_line_char;
   logic                    rsp_line_end;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   logic [BYTE_W-1:0]       line_copy [LINE_MAX];
   logic [CFG_W-1:0]        copy_fill;
   logic [CFG_W-1:0]        line_limit;
   line_word_type           pending_words [$];
   int                      mismatches = 0;
   int                      bytes_sent = 0;
   int                      burst_left = 0;
   int                      holds_asked = 0;
   int                      holds_granted = 0;
   int                      hold_left = 0;
   int                      mode_left = 0;
   ready_mode_type          ready_mode = READY_ALWAYS;
   int                      quiet_cycles = 0;

   serial_line_assembler #(.LINE_MAX(LINE_MAX)) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_line_char (rsp_line_char),
      .rsp_line_end  (rsp_line_end),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #10 clock = ~clock;

   function automatic void assemble_byte(input logic [BYTE_W-1:0] b, input bit publish);
      int n;
      int lim;
      int k;
      if (b != NL_BYTE) begin
         if (copy_fill < LINE_CAP) begin
            line_copy[copy_fill] = b;
            copy_fill = copy_fill + 1'b1;
         end else begin
            copy_fill = '0;
         end
         return;
      end
      n = copy_fill;
      copy_fill = '0;
      if (n > 0 && line_copy[n - 1] == CR_BYTE) n--;
      if (n == 0 || !publish) return;
      lim = (n < line_limit) ? n : line_limit;
      for (k = 0; k < lim; k++) begin
         if (line_copy[k] == NUL_BYTE) break;
         pending_words.push_back('{ch: line_copy[k], last: 1'b0});
      end
      pending_words.push_back('{ch: NUL_BYTE, last: 1'b1});
   endfunction

   function automatic logic [BYTE_W-1:0] line_body_byte();
      logic [BYTE_W-1:0] b;
      if ($urandom_range(0, 15) == 0) return NUL_BYTE;
      b = BYTE_W'($urandom_range(0, 255));
      while (b == NL_BYTE) b = BYTE_W'($urandom_range(0, 255));
      return b;
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b, input outcome_type outcome);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      assemble_byte(b, outcome == OUTCOME_MODEL);
      if (outcome == OUTCOME_END_ONLY) pending_words.push_back('{ch: NUL_BYTE, last: 1'b1});
   endtask

   task automatic send_line(input int len, input bit cr_end, input bit press);
      int k;
      for (k = 0; k < len; k++) send_byte(line_body_byte(), OUTCOME_MODEL);
      if (cr_end) send_byte(CR_BYTE, OUTCOME_MODEL);
      if (press) holds_asked++;
      send_byte(NL_BYTE, OUTCOME_MODEL);
   endtask

   task automatic set_line_limit(input logic [CFG_W-1:0] v);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom();
      data[CFG_W-1:0] = v;
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LIMIT_ADDR;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      line_limit = v;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {{(CSR_DATA_W - CFG_W){1'b0}}, v}) begin
         $display("%0t: max_out_len read back: expected %08h, got %08h",
                  $time, {{(CSR_DATA_W - CFG_W){1'b0}}, v}, csr_prdata);
         mismatches++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (holds_granted != holds_asked) begin
         holds_granted = holds_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(5, 60);
         end
         mode_left--;
         unique case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_HALF:   rsp_ready <= ($urandom_range(0, 1) == 1);
            READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
            default:      rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected line word: char %02h end %0b",
                     $time, rsp_line_char, rsp_line_end);
            mismatches++;
         end else begin
            if (rsp_line_char !== pending_words[0].ch || rsp_line_end !== pending_words[0].last)
            begin
               $display("%0t: line word mismatch: expected char %02h end %0b, got char %02h end %0b",
                        $time, pending_words[0].ch, pending_words[0].last,
                        rsp_line_char, rsp_line_end);
               mismatches++;
            end
            void'(pending_words.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("** serial_line_assembler: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      int r;
      int k;
      int phase;
      int lines_left;
      int shape;
      logic [CFG_W-1:0] v;
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      copy_fill = '0;
      line_limit = MAX_OUT_LEN_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIRECTED_ROWS; r++) begin
         unique case (DIRECTED[r].kind)
            ROW_LIMIT: set_line_limit(DIRECTED[r].value[CFG_W-1:0]);
            ROW_FILL: begin
               for (k = 0; k < DIRECTED[r].value; k++) begin
                  send_byte(FILL_BASE + BYTE_W'(k), OUTCOME_MODEL);
               end
            end
            default: send_byte(DIRECTED[r].value, DIRECTED[r].outcome);
         endcase
      end

      phase = 0;
      while (bytes_sent < ITEM_TARGET) begin
         unique case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = CFG_W'(1);
            default: v = CFG_W'($urandom_range(0, 63));
         endcase
         if (phase == 0) v = '1;
         set_line_limit(v);
         lines_left = $urandom_range(3, 8);
         while (lines_left > 0 && bytes_sent < ITEM_TARGET) begin
            shape = $urandom_range(0, 19);
            if (phase == 0 && lines_left > 0 && r == DIRECTED_ROWS) begin
               send_line(LINE_CAP, 1'b0, 1'b1);
               r++;
            end else if (shape < 2) begin
               for (k = $urandom_range(1, 6); k > 0; k--) begin
                  send_byte(BYTE_W'($urandom_range(0, 255)), OUTCOME_MODEL);
               end
            end else if (shape < 4) begin
               send_line($urandom_range(58, 66), 1'($urandom_range(0, 1)), 1'b0);
            end else if (shape == 4) begin
               send_line(0, 1'($urandom_range(0, 1)), 1'b0);
            end else begin
               send_line($urandom_range(1, 10), 1'($urandom_range(0, 1)), 1'b0);
            end
            lines_left--;
         end
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("** serial_line_assembler: PASSED **");
      end else begin
         $display("** serial_line_assembler: FAILED **");
      end
      $finish;
   end

endmodule
